// ===== rtl/bb3_pkg.sv =====
// ----------------------------------------------------------------------------
// bb3_pkg
// Shared types and constants of the 3x3 RGB box blur.
// ----------------------------------------------------------------------------
`default_nettype none

package bb3_pkg;

  localparam int ChanW   = 8;
  localparam int PixW    = 3 * ChanW;
  localparam int FwidthW = 12;
  localparam int FheightW = 16;

  // One shift step of the raster window, as the front hands it to the back.
  typedef struct packed {
    logic            emit;
    logic            last;
    logic            skip_top;
    logic            skip_bot;
    logic            skip_left;
    logic            skip_right;
    logic [PixW-1:0] px;
  } bb3_op_t;

endpackage

`default_nettype wire

// ===== rtl/bb3_in_if.sv =====
// ----------------------------------------------------------------------------
// bb3_in_if
// Pixel input channel: valid/ready with request type and RGB payload.
// ----------------------------------------------------------------------------
`default_nettype none

interface bb3_in_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;

  modport source (output valid, output req_type, output red, output green, output blue,
                  input ready);
  modport sink   (input valid, input req_type, input red, input green, input blue,
                  output ready);
endinterface

`default_nettype wire

// ===== rtl/bb3_out_if.sv =====
// ----------------------------------------------------------------------------
// bb3_out_if
// Blurred pixel output channel: valid/ready with RGB payload and frame end.
// ----------------------------------------------------------------------------
`default_nettype none

interface bb3_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_red;
  logic [7:0] out_green;
  logic [7:0] out_blue;
  logic       is_last;

  modport source (output valid, output out_red, output out_green, output out_blue,
                  output is_last, input ready);
  modport sink   (input valid, input out_red, input out_green, input out_blue,
                  input is_last, output ready);
endinterface

`default_nettype wire

// ===== rtl/box_blur_3x3_rgb.sv =====
// ----------------------------------------------------------------------------
// box_blur_3x3_rgb
// Streaming 3x3 box blur of a 24-bit RGB raster frame with APB setup port.
//
//   channel   dir   handshake            payload
//   pixels    in    valid/ready          req_type, red, green, blue
//   blurred   out   valid/ready          out_red, out_green, out_blue, is_last
//   apb       in    psel/penable/pwrite  paddr, pwdata, prdata (pready high)
//
// One item per cycle unless the queue is full; a single-row frame's first
// flush tick needs an extra silent shift in the front sequencer. Output k
// leaves with the item width+1 later, via the back pipe stages (store read, sum,
// multiply, fix-up). Reset clears positions and window; stores need no clear.
// A stalled output holds the back pipe; the 4-entry queue absorbs the front.
// ----------------------------------------------------------------------------
`default_nettype none

module box_blur_3x3_rgb #(
  parameter int MAX_WIDTH = 2048
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  bb3_in_if.sink      pixels,
  bb3_out_if.source   blurred
);

  import bb3_pkg::*;

  localparam int ColW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int QDepth = 4;
  localparam int QW = ColW + $bits(bb3_op_t);
  localparam logic RegWidth  = 1'b0;
  localparam logic RegHeight = 1'b1;

  logic [FwidthW-1:0]  frame_width;
  logic [FheightW-1:0] frame_height;
  logic                wr;

  logic            push;
  logic [ColW-1:0] push_col;
  bb3_op_t         push_op;
  logic            full;
  logic            pop;
  logic            empty;
  logic [QW-1:0]   q_dout;
  logic [ColW-1:0] op_col;
  bb3_op_t         op;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= 12'd640;
      frame_height <= 16'd480;
    end else if (wr) begin
      unique case (paddr[2])
        RegWidth:  frame_width  <= pwdata[FwidthW-1:0];
        RegHeight: frame_height <= pwdata[FheightW-1:0];
        default:   frame_width  <= frame_width;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      RegWidth:  prdata = 32'(frame_width);
      RegHeight: prdata = 32'(frame_height);
      default:   prdata = '0;
    endcase
  end

  bb3_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
    .clk          (clk),
    .rst          (rst),
    .restart      (wr),
    .frame_width  (frame_width),
    .frame_height (frame_height),
    .pixels       (pixels),
    .full         (full),
    .push         (push),
    .push_col     (push_col),
    .push_op      (push_op)
  );

  bb3_fifo #(.WIDTH(QW), .DEPTH(QDepth)) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .din   ({push_col, push_op}),
    .full  (full),
    .pop   (pop),
    .dout  (q_dout),
    .empty (empty)
  );

  assign op_col = q_dout[QW-1 -: ColW];
  assign op     = q_dout[$bits(bb3_op_t)-1:0];

  bb3_back #(.MAX_WIDTH(MAX_WIDTH)) u_back (
    .clk     (clk),
    .rst     (rst),
    .restart (wr),
    .empty   (empty),
    .op_col  (op_col),
    .op      (op),
    .pop     (pop),
    .blurred (blurred)
  );

endmodule

`default_nettype wire

// ===== rtl/bb3_ram.sv =====
// ----------------------------------------------------------------------------
// bb3_ram
// Simple dual-port RAM, one write and one registered read port, read-first.
// ----------------------------------------------------------------------------
`default_nettype none

module bb3_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 2048,
  localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AddrW-1:0] waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AddrW-1:0] raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/bb3_fifo.sv =====
// ----------------------------------------------------------------------------
// bb3_fifo
// Short register FIFO that decouples the front sequencer from the back pipe.
// ----------------------------------------------------------------------------
`default_nettype none

module bb3_fifo #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4,
  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CntW = $clog2(DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PtrW-1:0]  wptr;
  logic [PtrW-1:0]  rptr;
  logic [CntW-1:0]  count;

  assign full  = (count == CntW'(DEPTH));
  assign empty = (count == '0);
  assign dout  = mem[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == PtrW'(DEPTH - 1)) ? '0 : wptr + PtrW'(1);
      end
      if (pop) begin
        rptr <= (rptr == PtrW'(DEPTH - 1)) ? '0 : rptr + PtrW'(1);
      end
      unique case ({push, pop})
        2'b10:   count <= count + CntW'(1);
        2'b01:   count <= count - CntW'(1);
        default: count <= count;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("fifo push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> !empty)
    else $error("fifo pop while empty");
`endif

endmodule

`default_nettype wire

// ===== rtl/bb3_front.sv =====
// ----------------------------------------------------------------------------
// bb3_front
// Accepts input items, tracks raster positions and issues window shift steps.
// ----------------------------------------------------------------------------
`default_nettype none

module bb3_front #(
  parameter int MAX_WIDTH = 2048,
  localparam int ColW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1,
  localparam int WidW = $clog2(MAX_WIDTH + 1),
  localparam int CntW = $clog2(MAX_WIDTH + 2)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          restart,
  input  logic [bb3_pkg::FwidthW-1:0]   frame_width,
  input  logic [bb3_pkg::FheightW-1:0]  frame_height,
  bb3_in_if.sink                        pixels,
  input  logic                          full,
  output logic                          push,
  output logic [ColW-1:0]               push_col,
  output bb3_pkg::bb3_op_t              push_op
);

  import bb3_pkg::*;

  logic [WidW-1:0]     eff_w;
  logic [FheightW-1:0] eff_h;
  logic [ColW-1:0]     in_col;
  logic [FheightW-1:0] in_row;
  logic [ColW-1:0]     out_col;
  logic [FheightW-1:0] out_row;
  logic [CntW-1:0]     scnt;

  logic flush_phase;
  logic primed;
  logic in_wrap;
  logic out_wrap;
  logic bot_edge;
  logic last;
  logic accept;
  logic do_shift;
  logic emit;

  always_comb begin
    if (frame_width == '0) begin
      eff_w = WidW'(1);
    end else if (int'(frame_width) > MAX_WIDTH) begin
      eff_w = WidW'(MAX_WIDTH);
    end else begin
      eff_w = WidW'(frame_width);
    end
  end

  assign eff_h = (frame_height == '0) ? FheightW'(1) : frame_height;

  assign flush_phase = (in_row >= eff_h);
  assign primed      = (scnt >= (CntW'(eff_w) + CntW'(1)));
  assign in_wrap     = ((WidW'(in_col) + WidW'(1)) >= eff_w);
  assign out_wrap    = ((WidW'(out_col) + WidW'(1)) >= eff_w);
  assign bot_edge    = ((17'(out_row) + 17'd1) >= 17'(eff_h));
  assign last        = bot_edge && out_wrap;

  // single-row frames need one extra silent shift before the first flush output
  assign pixels.ready = !full && !(flush_phase && !primed);
  assign accept       = pixels.valid && pixels.ready;
  assign do_shift     = (accept && (flush_phase || !pixels.req_type)) ||
                        (pixels.valid && !full && flush_phase && !primed);
  assign emit         = do_shift && primed;

  assign push     = do_shift;
  assign push_col = in_col;

  always_comb begin
    push_op.emit       = emit;
    push_op.last       = last;
    push_op.skip_top   = (out_row == '0);
    push_op.skip_bot   = bot_edge;
    push_op.skip_left  = (out_col == '0);
    push_op.skip_right = out_wrap;
    push_op.px         = flush_phase ? '0 : {pixels.red, pixels.green, pixels.blue};
  end

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      in_col  <= '0;
      in_row  <= '0;
      out_col <= '0;
      out_row <= '0;
      scnt    <= '0;
    end else if (do_shift) begin
      if (emit && last) begin
        in_col  <= '0;
        in_row  <= '0;
        out_col <= '0;
        out_row <= '0;
        scnt    <= '0;
      end else begin
        if (in_wrap) begin
          in_col <= '0;
          if (!flush_phase) begin
            in_row <= in_row + FheightW'(1);
          end
        end else begin
          in_col <= in_col + ColW'(1);
        end
        if (!primed) begin
          scnt <= scnt + CntW'(1);
        end
        if (emit) begin
          if (out_wrap) begin
            out_col <= '0;
            out_row <= out_row + FheightW'(1);
          end else begin
            out_col <= out_col + ColW'(1);
          end
        end
      end
    end
  end

`ifndef SYNTHESIS
  a_out_pos_in_frame: assert property (@(posedge clk) disable iff (rst)
    (17'(out_row) < 17'(eff_h)) && (WidW'(out_col) < eff_w))
    else $error("output position outside frame");
`endif

endmodule

`default_nettype wire

// ===== rtl/bb3_back.sv =====
// ----------------------------------------------------------------------------
// bb3_back
// Line stores, 3x3 window, masked sums and rounded division to the output.
// ----------------------------------------------------------------------------
`default_nettype none

module bb3_back #(
  parameter int MAX_WIDTH = 2048,
  localparam int ColW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             restart,
  input  logic             empty,
  input  logic [ColW-1:0]  op_col,
  input  bb3_pkg::bb3_op_t op,
  output logic             pop,
  bb3_out_if.source        blurred
);

  import bb3_pkg::*;

  localparam int SumW = 12;
  localparam int NumW = 13;
  localparam int RecW = 16;
  localparam int DivW = 5;
  localparam int ProdW = NumW + RecW;
  localparam int RemW = NumW + DivW;

  function automatic logic [RecW-1:0] recip_of(input logic [DivW-1:0] d);
    logic [RecW-1:0] r;
    unique case (d)
      5'd2:    r = 16'd32768;
      5'd4:    r = 16'd16384;
      5'd6:    r = 16'd10922;
      5'd8:    r = 16'd8192;
      5'd12:   r = 16'd5461;
      5'd18:   r = 16'd3640;
      default: r = 16'd0;
    endcase
    return r;
  endfunction

  logic adv;

  logic            p1_valid;
  logic [ColW-1:0] p1_col;
  bb3_op_t         p1_op;
  logic            fwd;
  logic [PixW-1:0] fwd_top;
  logic [PixW-1:0] fwd_mid;
  logic [PixW-1:0] older_q;
  logic [PixW-1:0] newer_q;
  logic [PixW-1:0] top_px;
  logic [PixW-1:0] mid_px;

  logic [PixW-1:0] win      [3][3];
  logic [PixW-1:0] win_next [3][3];
  logic [2:0]      row_on;
  logic [2:0]      col_on;
  logic [9:0]      row_sum  [3][3];
  logic [SumW-1:0] tot      [3];
  logic [1:0]      rows;
  logic [1:0]      cols;
  logic [3:0]      cnt;

  logic            p2_valid;
  logic            p2_last;
  logic [NumW-1:0] p2_num [3];
  logic [DivW-1:0] p2_d;
  logic [RecW-1:0] p2_rec;

  logic             p3_valid;
  logic             p3_last;
  logic [NumW-1:0]  p3_num  [3];
  logic [DivW-1:0]  p3_d;
  logic [ProdW-1:0] p3_prod [3];

  logic [NumW-1:0] q_est [3];
  logic [RemW-1:0] rem   [3];
  logic [NumW-1:0] q     [3];

  assign adv = !blurred.valid || blurred.ready;
  assign pop = adv && !empty;

  bb3_ram #(.WIDTH(PixW), .DEPTH(MAX_WIDTH)) u_older (
    .clk   (clk),
    .we    (adv && p1_valid),
    .waddr (p1_col),
    .wdata (mid_px),
    .re    (adv),
    .raddr (op_col),
    .rdata (older_q)
  );

  bb3_ram #(.WIDTH(PixW), .DEPTH(MAX_WIDTH)) u_newer (
    .clk   (clk),
    .we    (adv && p1_valid),
    .waddr (p1_col),
    .wdata (p1_op.px),
    .re    (adv),
    .raddr (op_col),
    .rdata (newer_q)
  );

  // bypass the store when the previous step wrote the same column
  assign top_px = fwd ? fwd_top : older_q;
  assign mid_px = fwd ? fwd_mid : newer_q;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      win_next[r][0] = win[r][1];
      win_next[r][1] = win[r][2];
    end
    win_next[0][2] = top_px;
    win_next[1][2] = mid_px;
    win_next[2][2] = p1_op.px;
  end

  assign row_on = {!p1_op.skip_bot, 1'b1, !p1_op.skip_top};
  assign col_on = {!p1_op.skip_right, 1'b1, !p1_op.skip_left};
  assign rows   = 2'd3 - 2'(p1_op.skip_top) - 2'(p1_op.skip_bot);
  assign cols   = 2'd3 - 2'(p1_op.skip_left) - 2'(p1_op.skip_right);
  assign cnt    = 4'(rows) * 4'(cols);

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      for (int r = 0; r < 3; r++) begin
        row_sum[ch][r] = '0;
        for (int c = 0; c < 3; c++) begin
          if (row_on[r] && col_on[c]) begin
            row_sum[ch][r] = row_sum[ch][r] + 10'(win_next[r][c][(2 - ch) * ChanW +: ChanW]);
          end
        end
      end
      tot[ch] = SumW'(row_sum[ch][0]) + SumW'(row_sum[ch][1]) + SumW'(row_sum[ch][2]);
    end
  end

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      q_est[ch] = p3_prod[ch][ProdW-1:RecW];
      rem[ch]   = RemW'(p3_num[ch]) - (RemW'(q_est[ch]) * RemW'(p3_d));
      q[ch]     = (rem[ch] >= RemW'(p3_d)) ? q_est[ch] + NumW'(1) : q_est[ch];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid      <= 1'b0;
      fwd           <= 1'b0;
      p2_valid      <= 1'b0;
      p3_valid      <= 1'b0;
      blurred.valid <= 1'b0;
    end else if (adv) begin
      p1_valid      <= pop;
      fwd           <= p1_valid && pop && (op_col == p1_col);
      p2_valid      <= p1_valid && p1_op.emit;
      p3_valid      <= p2_valid;
      blurred.valid <= p3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p1_col  <= op_col;
      p1_op   <= op;
      fwd_top <= mid_px;
      fwd_mid <= p1_op.px;
      p2_last <= p1_op.last;
      p2_d    <= {cnt, 1'b0};
      p2_rec  <= recip_of({cnt, 1'b0});
      p3_last <= p2_last;
      p3_d    <= p2_d;
      for (int ch = 0; ch < 3; ch++) begin
        p2_num[ch]  <= {tot[ch], 1'b0} + NumW'(cnt);
        p3_num[ch]  <= p2_num[ch];
        p3_prod[ch] <= ProdW'(p2_num[ch]) * ProdW'(p2_rec);
      end
      blurred.out_red   <= q[0][ChanW-1:0];
      blurred.out_green <= q[1][ChanW-1:0];
      blurred.out_blue  <= q[2][ChanW-1:0];
      blurred.is_last   <= p3_last;
    end
  end

  // clear the window at frame end so the next frame starts from zero
  always_ff @(posedge clk) begin
    if (rst || restart) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          win[r][c] <= '0;
        end
      end
    end else if (adv && p1_valid) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          win[r][c] <= (p1_op.emit && p1_op.last) ? '0 : win_next[r][c];
        end
      end
    end
  end

`ifndef SYNTHESIS
  a_win_cleared_at_end: assert property (@(posedge clk) disable iff (rst)
    (adv && p1_valid && p1_op.emit && p1_op.last) |=>
      (win[0][2] == '0) && (win[1][2] == '0) && (win[2][2] == '0))
    else $error("window not cleared after frame end");
`endif

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the streaming 3x3 RGB box blur.
//
// Sets the frame size over APB while the block is idle and streams raster
// frames through the pixel channel. Flush ticks go in mid-frame and in the
// drain, and some frames are cut short. A bench-side model of the line stores
// and window predicts every blurred pixel, and each pixel is compared field by
// field. Both channels idle and stall in random bursts. Frame sizes cover
// 1x1 up to the maximum width and height, including zero and clamped values.
// ----------------------------------------------------------------------------
module tb_top;
  import bb3_pkg::*;

  localparam int          MAX_W         = 2048;
  localparam logic        REQ_PIXEL     = 1'b0;
  localparam logic        REQ_FLUSH     = 1'b1;
  localparam logic [2:0]  REG_FRAME_WIDTH  = 3'd0;
  localparam logic [2:0]  REG_FRAME_HEIGHT = 3'd4;
  localparam int          SETTLE_CYCLES = 16;
  localparam int          DRAIN_LIMIT   = 200000;
  localparam int          RANDOM_ITEMS  = 700;
  localparam int          WIDE_CUT      = 40;
  localparam int          REPORT_LIMIT  = 20;
  localparam int unsigned CUT_NONE      = 32'hFFFF_FFFF;

  typedef struct packed {
    logic             req_type;
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
  } pixel_req_t;

  typedef struct packed {
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
    logic             is_last;
  } blur_pix_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  bb3_in_if  pix_if ();
  bb3_out_if blur_if ();

  box_blur_3x3_rgb #(.MAX_WIDTH(MAX_W)) uut (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .pixels  (pix_if),
    .blurred (blur_if)
  );

  always #5 clk = ~clk;

  // blur model state
  logic [FwidthW-1:0]  width_reg;
  logic [FheightW-1:0] height_reg;
  logic [PixW-1:0]     older_rows [MAX_W];
  logic [PixW-1:0]     newer_rows [MAX_W];
  logic [PixW-1:0]     win [3][3];
  int unsigned         col_in, row_in, col_out, row_out;
  longint unsigned     shift_count;

  blur_pix_t   blurred_expected [$];
  blur_pix_t   want_pix;
  int unsigned errors, transfers, results_checked, frames_done, useful_items;
  bit          send_gaps, recv_stalls;

  function automatic int unsigned eff_width();
    if (width_reg == 0) return 1;
    if (width_reg > MAX_W) return MAX_W;
    return width_reg;
  endfunction

  function automatic int unsigned eff_height();
    return (height_reg == 0) ? 1 : height_reg;
  endfunction

  function automatic void restart_frame();
    win = '{default: '0};
    col_in = 0;
    row_in = 0;
    col_out = 0;
    row_out = 0;
    shift_count = 0;
  endfunction

  function automatic void shift_column(logic [PixW-1:0] px);
    logic [PixW-1:0] top, mid;
    int r;
    top = older_rows[col_in];
    mid = newer_rows[col_in];
    older_rows[col_in] = mid;
    newer_rows[col_in] = px;
    for (r = 0; r < 3; r++) begin
      win[r][0] = win[r][1];
      win[r][1] = win[r][2];
    end
    win[0][2] = top;
    win[1][2] = mid;
    win[2][2] = px;
    col_in++;
    if (col_in >= eff_width()) begin
      col_in = 0;
      row_in++;
    end
    shift_count++;
  endfunction

  function automatic logic [ChanW-1:0] rounded_mean(int unsigned sum, int unsigned n);
    return ChanW'((2 * sum + n) / (2 * n));
  endfunction

  function automatic blur_pix_t blur_at();
    int unsigned w, h, sum_r, sum_g, sum_b, n;
    int r, c;
    blur_pix_t res;
    w = eff_width();
    h = eff_height();
    sum_r = 0;
    sum_g = 0;
    sum_b = 0;
    n = 0;
    for (r = 0; r < 3; r++) begin
      for (c = 0; c < 3; c++) begin
        if (!((r == 0 && row_out == 0) || (r == 2 && row_out + 1 >= h) ||
              (c == 0 && col_out == 0) || (c == 2 && col_out + 1 >= w))) begin
          sum_r += win[r][c][2*ChanW +: ChanW];
          sum_g += win[r][c][ChanW +: ChanW];
          sum_b += win[r][c][0 +: ChanW];
          n++;
        end
      end
    end
    if (n == 0) n = 1;
    res.red     = rounded_mean(sum_r, n);
    res.green   = rounded_mean(sum_g, n);
    res.blue    = rounded_mean(sum_b, n);
    res.is_last = (row_out + 1 >= h) && (col_out + 1 >= w);
    if (res.is_last) begin
      restart_frame();
      frames_done++;
    end else begin
      col_out++;
      if (col_out >= w) begin
        col_out = 0;
        row_out++;
      end
    end
    return res;
  endfunction

  function automatic void predict_blur(pixel_req_t it);
    longint unsigned lag;
    int k;
    lag = eff_width() + 1;
    if (row_in < eff_height()) begin
      if (it.req_type == REQ_FLUSH) return;
      shift_column({it.red, it.green, it.blue});
      if (shift_count > lag) blurred_expected.push_back(blur_at());
    end else begin
      for (k = 0; k < 3; k++) begin
        shift_column('0);
        if (shift_count > lag) begin
          blurred_expected.push_back(blur_at());
          break;
        end
      end
    end
  endfunction

  function automatic void note_mismatch(string what, logic [31:0] want, logic [31:0] got);
    errors++;
    if (errors <= REPORT_LIMIT)
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
  endfunction

  function automatic logic [ChanW-1:0] random_channel();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return ChanW'($urandom);
    endcase
  endfunction

  function automatic pixel_req_t make_req(logic kind, logic [ChanW-1:0] r, g, b);
    pixel_req_t it;
    it.req_type = kind;
    it.red      = r;
    it.green    = g;
    it.blue     = b;
    return it;
  endfunction

  function automatic pixel_req_t random_req(logic kind);
    return make_req(kind, random_channel(), random_channel(), random_channel());
  endfunction

  task automatic send_item(pixel_req_t it);
    @(negedge clk);
    if (send_gaps && $urandom_range(0, 3) == 0) begin
      pix_if.valid = 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk);
    end
    pix_if.valid    = 1'b1;
    pix_if.req_type = it.req_type;
    pix_if.red      = it.red;
    pix_if.green    = it.green;
    pix_if.blue     = it.blue;
    do @(posedge clk); while (!pix_if.ready);
    transfers++;
    predict_blur(it);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    pix_if.valid = 1'b0;
    while (blurred_expected.size() != 0) @(posedge clk);
  endtask

  task automatic apb_write(logic [2:0] addr, logic [31:0] data);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = addr;
    pwdata  = data;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    case (addr)
      REG_FRAME_WIDTH: begin
        width_reg = data[FwidthW-1:0];
        restart_frame();
      end
      REG_FRAME_HEIGHT: begin
        height_reg = data[FheightW-1:0];
        restart_frame();
      end
      default: ;
    endcase
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic check_register(string what, logic [2:0] addr, logic [31:0] want);
    logic [31:0] got;
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = addr;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    got = prdata;
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    if (got !== want) note_mismatch(what, want, got);
  endtask

  task automatic set_frame(logic [31:0] w, logic [31:0] h);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    apb_write(REG_FRAME_WIDTH, w);
    apb_write(REG_FRAME_HEIGHT, h);
  endtask

  // Stream one frame, or its first cut pixels; a whole frame is followed by
  // the ticks that drain it (pixel or flush at random).
  task automatic run_frame(int unsigned cut, bit noisy);
    int unsigned w, h, i, drain;
    w = eff_width();
    h = eff_height();
    for (i = 0; i < w * h && i < cut; i++) begin
      if (noisy && $urandom_range(0, 15) == 0) send_item(random_req(REQ_FLUSH));
      if (noisy && $urandom_range(0, 63) == 0) wait_drained();
      send_item(random_req(REQ_PIXEL));
      useful_items++;
    end
    if (cut >= w * h) begin
      drain = (h == 1) ? w : w + 1;
      for (i = 0; i < drain; i++) begin
        send_item(random_req($urandom_range(0, 1) ? REQ_FLUSH : REQ_PIXEL));
        useful_items++;
      end
    end
  endtask

  task automatic test_register_access();
    check_register("frame_width reset", REG_FRAME_WIDTH, 32'd640);
    check_register("frame_height reset", REG_FRAME_HEIGHT, 32'd480);
    apb_write(REG_FRAME_WIDTH, ($urandom & 32'hFFFF_F000) | 32'd37);
    check_register("frame_width readback", REG_FRAME_WIDTH, 32'd37);
    apb_write(REG_FRAME_HEIGHT, ($urandom & 32'hFFFF_0000) | 32'd1234);
    check_register("frame_height readback", REG_FRAME_HEIGHT, 32'd1234);
  endtask

  task automatic test_directed_frames();
    set_frame(1, 1);
    run_frame(CUT_NONE, 1'b0);
    set_frame(3, 1);
    run_frame(CUT_NONE, 1'b0);
    set_frame(1, 3);
    run_frame(CUT_NONE, 1'b0);
    // 2x2 of extremes: every mean lands on a half and rounds up
    set_frame(2, 2);
    send_item(make_req(REQ_PIXEL, 8'h00, 8'hFF, 8'h00));
    send_item(make_req(REQ_PIXEL, 8'hFF, 8'hFF, 8'hFF));
    send_item(make_req(REQ_FLUSH, 8'hFF, 8'h00, 8'hFF));
    send_item(make_req(REQ_PIXEL, 8'hFF, 8'h00, 8'h00));
    send_item(make_req(REQ_PIXEL, 8'h00, 8'h00, 8'hFF));
    send_item(make_req(REQ_PIXEL, 8'h55, 8'hAA, 8'h01));
    send_item(make_req(REQ_FLUSH, 8'h00, 8'h00, 8'h00));
    send_item(make_req(REQ_FLUSH, 8'hFF, 8'hFF, 8'hFF));
  endtask

  task automatic test_size_extremes();
    set_frame(0, 0);
    run_frame(CUT_NONE, 1'b0);
    set_frame(1, 32'hFFFF);
    run_frame(40, 1'b0);
    set_frame(MAX_W, 32'hFFFF);
    run_frame(WIDE_CUT, 1'b0);
    set_frame(32'hFFF, 2);
    run_frame(WIDE_CUT, 1'b0);
  endtask

  task automatic test_random_frames();
    int unsigned start, w, h, cut, total;
    bit keep, quiet;
    start = useful_items;
    keep  = 1'b0;
    while (useful_items - start < RANDOM_ITEMS) begin
      quiet       = (useful_items - start) > (RANDOM_ITEMS * 85 / 100);
      send_gaps   = !quiet && $urandom_range(0, 2) != 0;
      recv_stalls = !quiet && $urandom_range(0, 2) != 0;
      if (!keep) begin
        case ($urandom_range(0, 19))
          0:          w = 0;
          1, 2, 3, 4: w = $urandom_range(7, 40);
          default:    w = $urandom_range(1, 6);
        endcase
        case ($urandom_range(0, 9))
          0:       h = 0;
          1:       h = (w <= 6) ? $urandom_range(6, 12) : $urandom_range(1, 3);
          default: h = $urandom_range(1, 5);
        endcase
        set_frame(w, h);
      end
      total = eff_width() * eff_height();
      if (!quiet && $urandom_range(0, 7) == 0) begin
        cut  = $urandom_range(0, total - 1);
        keep = 1'b0;
      end else begin
        cut  = CUT_NONE;
        keep = $urandom_range(0, 1);
      end
      run_frame(cut, !quiet);
    end
  endtask

  always @(posedge clk) begin
    if (!rst && blur_if.valid && blur_if.ready) begin
      results_checked++;
      if (blurred_expected.size() == 0) begin
        errors++;
        if (errors <= REPORT_LIMIT)
          $display("%0t: blurred pixel with none expected, actual r=%0d g=%0d b=%0d last=%0d",
                   $time, blur_if.out_red, blur_if.out_green, blur_if.out_blue,
                   blur_if.is_last);
      end else begin
        want_pix = blurred_expected.pop_front();
        if (blur_if.out_red !== want_pix.red)
          note_mismatch("out_red", want_pix.red, blur_if.out_red);
        if (blur_if.out_green !== want_pix.green)
          note_mismatch("out_green", want_pix.green, blur_if.out_green);
        if (blur_if.out_blue !== want_pix.blue)
          note_mismatch("out_blue", want_pix.blue, blur_if.out_blue);
        if (blur_if.is_last !== want_pix.is_last)
          note_mismatch("is_last", want_pix.is_last, blur_if.is_last);
      end
    end
  end

  initial begin
    int unsigned hold;
    hold = 0;
    blur_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold != 0) begin
        hold--;
        blur_if.ready = 1'b0;
      end else if (recv_stalls && $urandom_range(0, 4) == 0) begin
        hold = $urandom_range(0, 9);
        blur_if.ready = 1'b0;
      end else begin
        blur_if.ready = 1'b1;
      end
    end
  end

  initial begin
    int unsigned waited;
    rst             = 1'b1;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    pix_if.valid    = 1'b0;
    pix_if.req_type = REQ_PIXEL;
    pix_if.red      = '0;
    pix_if.green    = '0;
    pix_if.blue     = '0;
    width_reg       = 640;
    height_reg      = 480;
    older_rows      = '{default: '0};
    newer_rows      = '{default: '0};
    restart_frame();
    errors          = 0;
    transfers       = 0;
    results_checked = 0;
    frames_done     = 0;
    useful_items    = 0;
    send_gaps       = 1'b1;
    recv_stalls     = 1'b1;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_register_access();
    test_directed_frames();
    test_size_extremes();
    test_random_frames();

    @(negedge clk);
    pix_if.valid = 1'b0;
    waited = 0;
    while (blurred_expected.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (blurred_expected.size() != 0) begin
      errors++;
      $display("%0t: %0d blurred pixels never arrived", $time, blurred_expected.size());
    end
    $display("run: %0d input transfers, %0d blurred pixels checked, %0d whole frames",
             transfers, results_checked, frames_done);
    $display({"run: sizes 1x1 up to 2048 wide and 65535 high, zero and clamped sizes, ",
              "flush ticks mid-frame and in the drain, cut frames"});
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #(8_000_000);
    $display("status: fail");
    $finish;
  end

endmodule
